FILE: sv/tcpop_pkg.sv
// Package for the TCP option parser: option kinds, lengths and result type.
// No dependencies; imported by tcpop_parser, tcp_option_parser and the testbench.
package tcpop_pkg;

    localparam logic [7:0] KIND_END    = 8'd0;
    localparam logic [7:0] KIND_NOP    = 8'd1;
    localparam logic [7:0] KIND_MSS    = 8'd2;
    localparam logic [7:0] KIND_WSCALE = 8'd3;
    localparam logic [7:0] KIND_SACK   = 8'd4;
    localparam logic [7:0] KIND_TS     = 8'd8;

    localparam logic [7:0] LEN_MSS     = 8'd4;
    localparam logic [7:0] LEN_WSCALE  = 8'd3;
    localparam logic [7:0] LEN_SACK    = 8'd2;
    localparam logic [7:0] LEN_TS      = 8'd10;
    // shortest legal length byte (kind and length alone)
    localparam logic [7:0] LEN_MIN     = 8'd2;

    // option byte positions: kind, length, first data byte
    localparam logic [7:0] POS_KIND    = 8'd0;
    localparam logic [7:0] POS_LEN     = 8'd1;
    localparam logic [7:0] POS_DATA0   = 8'd2;

    typedef struct packed {
        logic [15:0] mss_value;
        logic [7:0]  shift_count;
        logic        sack_permitted;
        logic        timestamps_present;
        logic        nop_present;
    } t_result;

endpackage

FILE: sv/tcpop_if.sv
// Valid/ready channel interfaces for option bytes in and parse results out.
// Independent of the package; payload widths follow the field list.
interface tcpop_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] option_byte;
    logic       last_byte;

    modport source (output valid, output option_byte, output last_byte, input ready);
    modport sink   (input valid, input option_byte, input last_byte, output ready);
endinterface

interface tcpop_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] mss_value;
    logic [7:0]  shift_count;
    logic        sack_permitted;
    logic        timestamps_present;
    logic        nop_present;

    modport source (output valid, output mss_value, output shift_count,
                    output sack_permitted, output timestamps_present,
                    output nop_present, input ready);
    modport sink   (input valid, input mss_value, input shift_count,
                    input sack_permitted, input timestamps_present,
                    input nop_present, output ready);
endinterface

FILE: sv/tcpop_parser.sv
// Option walk state and per-byte update for the TCP option parser.
// Depends on tcpop_pkg for option codes and the result struct.
module tcpop_parser
    import tcpop_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_result    o_result
);

    logic        r_stopped, n_stopped;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_upper, n_upper;
    t_result     r_held, n_held;

    logic        fin;
    logic [7:0]  fin_len;
    logic [8:0]  pos_inc;

    assign pos_inc = {1'b0, r_pos} + 9'd1;

    // walk kind / length / data for one byte
    always_comb begin
        n_stopped = r_stopped;
        n_kind    = r_kind;
        n_len     = r_len;
        n_pos     = r_pos;
        n_upper   = r_upper;
        n_held    = r_held;
        fin       = 1'b0;
        fin_len   = r_len;
        if (!r_stopped) begin
            if (r_pos == POS_KIND) begin
                if (i_byte == KIND_END) begin
                    n_stopped = 1'b1;
                end else if (i_byte == KIND_NOP) begin
                    n_held.nop_present = 1'b1;
                end else begin
                    n_kind = i_byte;
                    n_pos  = POS_LEN;
                end
            end else if (r_pos == POS_LEN) begin
                if (i_byte < LEN_MIN) begin
                    n_stopped = 1'b1;
                    n_pos     = POS_KIND;
                end else begin
                    n_len = i_byte;
                    if (i_byte == LEN_MIN) begin
                        fin     = 1'b1;
                        fin_len = i_byte;
                    end else begin
                        n_pos = POS_DATA0;
                    end
                end
            end else begin
                if (r_pos == POS_DATA0) begin
                    n_upper = i_byte;
                end
                if (pos_inc == {1'b0, r_len}) begin
                    fin = 1'b1;
                end else begin
                    n_pos = pos_inc[7:0];
                end
            end
        end

        // commit a complete option of a recognized kind and length
        if (fin) begin
            n_pos = POS_KIND;
            if (r_kind == KIND_MSS && fin_len == LEN_MSS) begin
                n_held.mss_value = {r_upper, i_byte};
            end else if (r_kind == KIND_WSCALE && fin_len == LEN_WSCALE) begin
                n_held.shift_count = i_byte;
            end else if (r_kind == KIND_SACK && fin_len == LEN_SACK) begin
                n_held.sack_permitted = 1'b1;
            end else if (r_kind == KIND_TS && fin_len == LEN_TS) begin
                n_held.timestamps_present = 1'b1;
            end
        end
    end

    assign o_result = n_held;

    // hold walk state; clear it after the final byte of an area
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_stopped <= 1'b0;
            r_kind    <= '0;
            r_len     <= '0;
            r_pos     <= POS_KIND;
            r_upper   <= '0;
            r_held    <= '0;
        end else if (i_take) begin
            r_stopped <= n_stopped;
            r_kind    <= n_kind;
            r_len     <= n_len;
            r_pos     <= n_pos;
            r_upper   <= n_upper;
            r_held    <= n_held;
        end
    end

endmodule

FILE: sv/tcp_option_parser.sv
// TCP option parser: one option byte per request, one result per option area.
// An input register feeds the byte walk; a final byte passes it, then the
// result register, which lets the next area stream in while a result waits.
// Throughput: 1 byte per cycle unless a final byte waits on a held result.
// Reset (synchronous, active low) empties both registers and clears the walk.
module tcp_option_parser
    import tcpop_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcpop_in_if.sink     i_in,
    tcpop_out_if.source  o_out
);

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       r_res_valid;
    t_result    r_res;

    logic       res_free;
    logic       s1_adv;
    t_result    walk_result;

    assign res_free   = !r_res_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && (!r_s1_last || res_free);
    assign i_in.ready = !r_s1_valid || s1_adv;

    // capture the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.ready) begin
            r_s1_byte <= i_in.option_byte;
            r_s1_last <= i_in.last_byte;
        end
    end

    tcpop_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (s1_adv),
        .i_byte   (r_s1_byte),
        .i_last   (r_s1_last),
        .o_result (walk_result)
    );

    // hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (s1_adv && r_s1_last) begin
            r_res_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_res_valid <= 1'b0;
        end
        if (s1_adv && r_s1_last) begin
            r_res <= walk_result;
        end
    end

    assign o_out.valid              = r_res_valid;
    assign o_out.mss_value          = r_res.mss_value;
    assign o_out.shift_count        = r_res.shift_count;
    assign o_out.sack_permitted     = r_res.sack_permitted;
    assign o_out.timestamps_present = r_res.timestamps_present;
    assign o_out.nop_present        = r_res.nop_present;

endmodule

FILE: sv/tcpop_checker.sv
// Port-level assertions for tcp_option_parser, attached by bind.
// Depends on the top level's interface ports only.
module tcpop_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_mss
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its mss value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_mss))
        else $error("result payload changed while stalled");

    // a new result follows an accepted final byte request
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("result without a final byte");

    // with no result waiting, requests are always taken
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind tcp_option_parser tcpop_checker u_tcpop_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_byte),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_mss   (o_out.mss_value)
);

FILE: sim/tb_tcp_option_parser.sv
`timescale 1ns / 100ps
// Testbench for tcp_option_parser: a directed table with set results, and random areas
// checked against an in-bench option walk. Depends on tcpop_pkg, tcpop_if and the parser RTL.
module tb_tcp_option_parser;
    import tcpop_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        logic [7:0] opt_byte;
        logic       last;
        logic       typed;
        t_result    result;
    } t_area_row;

    localparam logic [7:0] RECOGNISED_KINDS [4] = '{KIND_MSS, KIND_WSCALE, KIND_SACK, KIND_TS};
    localparam int DIRECTED_ROWS = 27;

    logic i_clk;
    logic i_rst_n;

    tcpop_in_if  byte_ch ();
    tcpop_out_if result_ch ();

    tcp_option_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (result_ch)
    );

    t_area_row directed_rows [DIRECTED_ROWS] = '{
        // end of list: the nop after it is ignored
        '{KIND_END,   1'b0, 1'b0, t_result'(0)},
        '{KIND_NOP,   1'b1, 1'b1, t_result'(0)},
        // nop, then mss, window scale and sack permitted at their extremes
        '{KIND_NOP,    1'b0, 1'b0, t_result'(0)},
        '{KIND_MSS,    1'b0, 1'b0, t_result'(0)},
        '{LEN_MSS,     1'b0, 1'b0, t_result'(0)},
        '{8'hFF,       1'b0, 1'b0, t_result'(0)},
        '{8'hFF,       1'b0, 1'b0, t_result'(0)},
        '{KIND_WSCALE, 1'b0, 1'b0, t_result'(0)},
        '{LEN_WSCALE,  1'b0, 1'b0, t_result'(0)},
        '{8'hFF,       1'b0, 1'b0, t_result'(0)},
        '{KIND_SACK,   1'b0, 1'b0, t_result'(0)},
        '{LEN_SACK,    1'b1, 1'b1, {16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b1}},
        // length below the minimum stops the walk
        '{8'hFF,      1'b0, 1'b0, t_result'(0)},
        '{8'h01,      1'b1, 1'b1, t_result'(0)},
        // mss cut short by the end of the area
        '{KIND_MSS,   1'b0, 1'b0, t_result'(0)},
        '{LEN_MSS,    1'b0, 1'b0, t_result'(0)},
        '{8'h12,      1'b1, 1'b1, t_result'(0)},
        // complete timestamps option
        '{KIND_TS,    1'b0, 1'b0, t_result'(0)},
        '{LEN_TS,     1'b0, 1'b0, t_result'(0)},
        '{8'h00,      1'b0, 1'b0, t_result'(0)},
        '{8'hFF,      1'b0, 1'b0, t_result'(0)},
        '{8'h00,      1'b0, 1'b0, t_result'(0)},
        '{8'hFF,      1'b0, 1'b0, t_result'(0)},
        '{8'h55,      1'b0, 1'b0, t_result'(0)},
        '{8'hAA,      1'b0, 1'b0, t_result'(0)},
        '{8'h00,      1'b0, 1'b0, t_result'(0)},
        '{8'hFF,      1'b1, 1'b1, {16'h0000, 8'h00, 1'b0, 1'b1, 1'b0}}
    };

    // option walk state
    logic       walk_stopped;
    logic [7:0] opt_kind;
    logic [7:0] opt_len;
    logic [7:0] opt_pos;
    logic [7:0] mss_hi;
    t_result    held_options;

    t_result    parse_results_due [$];
    logic [7:0] area_bytes [$];

    logic       req_typed;
    t_result    req_result;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         mismatch_count;
    int         stall_cycles;
    int         bytes_sent;
    t_result    observed_result;

    assign observed_result = {result_ch.mss_value, result_ch.shift_count,
                              result_ch.sack_permitted, result_ch.timestamps_present,
                              result_ch.nop_present};

    function automatic void clear_option_walk();
        walk_stopped = 1'b0;
        opt_kind     = '0;
        opt_len      = '0;
        opt_pos      = POS_KIND;
        mss_hi       = '0;
        held_options = '0;
    endfunction

    // commit a complete option whose last byte is b
    function automatic void commit_option(logic [7:0] b);
        if (opt_kind == KIND_MSS && opt_len == LEN_MSS) begin
            held_options.mss_value = {mss_hi, b};
        end else if (opt_kind == KIND_WSCALE && opt_len == LEN_WSCALE) begin
            held_options.shift_count = b;
        end else if (opt_kind == KIND_SACK && opt_len == LEN_SACK) begin
            held_options.sack_permitted = 1'b1;
        end else if (opt_kind == KIND_TS && opt_len == LEN_TS) begin
            held_options.timestamps_present = 1'b1;
        end
        opt_pos = POS_KIND;
    endfunction

    function automatic void walk_option_byte(logic [7:0] b);
        if (walk_stopped) begin
            return;
        end
        if (opt_pos == POS_KIND) begin
            if (b == KIND_END) begin
                walk_stopped = 1'b1;
            end else if (b == KIND_NOP) begin
                held_options.nop_present = 1'b1;
            end else begin
                opt_kind = b;
                opt_pos  = POS_LEN;
            end
        end else if (opt_pos == POS_LEN) begin
            if (b < LEN_MIN) begin
                walk_stopped = 1'b1;
                opt_pos      = POS_KIND;
            end else begin
                opt_len = b;
                if (b == LEN_MIN) begin
                    commit_option(b);
                end else begin
                    opt_pos = POS_DATA0;
                end
            end
        end else begin
            if (opt_pos == POS_DATA0) begin
                mss_hi = b;
            end
            if ({1'b0, opt_pos} + 9'd1 == {1'b0, opt_len}) begin
                commit_option(b);
            end else begin
                opt_pos = opt_pos + 8'd1;
            end
        end
    endfunction

    // clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // receiver stalls
    always @(posedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // predict on every accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            walk_option_byte(byte_ch.option_byte);
            if (byte_ch.last_byte) begin
                parse_results_due.push_back(req_typed ? req_result : held_options);
                clear_option_walk();
            end
        end
    end

    // compare every accepted result with the oldest one due
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (parse_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected result: mss %h shift %h sack %b ts %b nop %b",
                             observed_result.mss_value, observed_result.shift_count,
                             observed_result.sack_permitted,
                             observed_result.timestamps_present,
                             observed_result.nop_present);
                end
            end else begin
                want = parse_results_due.pop_front();
                if (observed_result.mss_value !== want.mss_value
                        || observed_result.shift_count !== want.shift_count
                        || observed_result.sack_permitted !== want.sack_permitted
                        || observed_result.timestamps_present !== want.timestamps_present
                        || observed_result.nop_present !== want.nop_present) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("exp/got mss %h/%h shift %h/%h sack %b/%b ts %b/%b nop %b/%b",
                                 want.mss_value, observed_result.mss_value,
                                 want.shift_count, observed_result.shift_count,
                                 want.sack_permitted, observed_result.sack_permitted,
                                 want.timestamps_present, observed_result.timestamps_present,
                                 want.nop_present, observed_result.nop_present);
                    end
                end
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tcp_option_parser regression: fail");
                $finish;
            end
        end
    end

    // offer one byte, idling first at random, and hold it until accepted
    task automatic send_option_byte(input logic [7:0] b, input logic last,
                                    input logic typed, input t_result result);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.option_byte <= b;
        byte_ch.last_byte   <= last;
        req_typed           <= typed;
        req_result          <= result;
        do begin
            @(posedge i_clk);
        end while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // drop valid and wait until every result due has arrived
    task automatic hold_until_drained();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (parse_results_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic push_random_bytes(input int count);
        repeat (count) area_bytes.push_back(8'($urandom_range(255)));
    endtask

    // build one option area: mostly well-formed options, some noise and cut tails
    task automatic build_random_area();
        int len;
        int cut;
        logic [7:0] kind;
        area_bytes.delete();
        if ($urandom_range(99) < 8) begin
            push_random_bytes($urandom_range(1, 12));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(9))
                    0: begin
                        area_bytes.push_back(KIND_NOP);
                    end
                    1: begin
                        area_bytes.push_back(KIND_MSS);
                        area_bytes.push_back(LEN_MSS);
                        push_random_bytes(2);
                    end
                    2: begin
                        area_bytes.push_back(KIND_WSCALE);
                        area_bytes.push_back(LEN_WSCALE);
                        push_random_bytes(1);
                    end
                    3: begin
                        area_bytes.push_back(KIND_SACK);
                        area_bytes.push_back(LEN_SACK);
                    end
                    4: begin
                        area_bytes.push_back(KIND_TS);
                        area_bytes.push_back(LEN_TS);
                        push_random_bytes(LEN_TS - 2);
                    end
                    5, 6: begin
                        // any kind but end and nop, mostly short lengths, rarely a long one
                        kind = 8'($urandom_range(2, 255));
                        len  = ($urandom_range(31) == 0) ? $urandom_range(13, 255)
                                                         : $urandom_range(2, 12);
                        area_bytes.push_back(kind);
                        area_bytes.push_back(8'(len));
                        push_random_bytes(len - 2);
                    end
                    7: begin
                        // known kind with any length from 2 to 12
                        len = $urandom_range(2, 12);
                        area_bytes.push_back(RECOGNISED_KINDS[$urandom_range(3)]);
                        area_bytes.push_back(8'(len));
                        push_random_bytes(len - 2);
                    end
                    8: begin
                        // length below the minimum, then leftovers
                        area_bytes.push_back(8'($urandom_range(2, 255)));
                        area_bytes.push_back(8'($urandom_range(0, 1)));
                        push_random_bytes($urandom_range(0, 3));
                    end
                    default: begin
                        area_bytes.push_back(KIND_END);
                        push_random_bytes($urandom_range(0, 3));
                    end
                endcase
            end
            // cut a random tail, which can leave the final option unfinished
            if ($urandom_range(99) < 20 && area_bytes.size() > 1) begin
                cut = $urandom_range(1, area_bytes.size() - 1);
                repeat (cut) area_bytes.pop_back();
            end
        end
    endtask

    task automatic set_idle_phase(input int phase);
        case (phase)
            0: begin
                send_idle_pct = 31;
                recv_idle_pct = 62;
            end
            1: begin
                send_idle_pct = 62;
                recv_idle_pct = 31;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // stimulus
    initial begin
        int phase;
        int next_phase;
        i_rst_n              = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.option_byte  = '0;
        byte_ch.last_byte    = 1'b0;
        result_ch.ready      = 1'b0;
        req_typed            = 1'b0;
        req_result           = '0;
        mismatch_count       = 0;
        stall_cycles         = 0;
        bytes_sent           = 0;
        phase                = 0;
        set_idle_phase(phase);
        clear_option_walk();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[i]) begin
            send_option_byte(directed_rows[i].opt_byte, directed_rows[i].last,
                             directed_rows[i].typed, directed_rows[i].result);
        end
        hold_until_drained();

        // random areas, three idle phases, drained at each change
        bytes_sent = 0;
        while (bytes_sent < RANDOM_ITEMS) begin
            build_random_area();
            foreach (area_bytes[i]) begin
                send_option_byte(area_bytes[i], i == area_bytes.size() - 1, 1'b0, '0);
            end
            next_phase = bytes_sent * 3 / RANDOM_ITEMS;
            if (next_phase != phase && next_phase < 3) begin
                hold_until_drained();
                phase = next_phase;
                set_idle_phase(phase);
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && parse_results_due.size() == 0) begin
            $display("tcp_option_parser regression: pass");
        end else begin
            $display("tcp_option_parser regression: fail");
        end
        $finish;
    end

endmodule
